/* rtl/core/sqt_pkg.sv */
// ----------------------------------------------------------------------------
// sqt_pkg
// Types and character constants shared by the shell quote tokenizer.
// ----------------------------------------------------------------------------
package sqt_pkg;

    localparam int SQT_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOL  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_CHAR        = 2'd0,
        KIND_TOKEN_END   = 2'd1,
        KIND_SEGMENT_END = 2'd2,
        KIND_LINE_END    = 2'd3
    } t_kind;

    // bit positions in a command mask, in emission order
    localparam int MB_CHAR     = 0;
    localparam int MB_TOKEN    = 1;
    localparam int MB_SEGMENT  = 2;
    localparam int MB_LINE     = 3;
    localparam int MASK_W      = 4;

    typedef struct packed {
        t_op        operation;
        logic [7:0] char_in;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_out;
        logic       last;
    } t_out;

    // one accepted item, reduced to the results it causes
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [7:0]        ch;
    } t_cmd;

endpackage

/* rtl/core/sqt_front.sv */
// ----------------------------------------------------------------------------
// sqt_front
// Lexer state and classification: turns each accepted item into a command.
// ----------------------------------------------------------------------------
module sqt_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  sqt_pkg::t_in i_in,
    output sqt_pkg::t_cmd o_cmd
);
    import sqt_pkg::*;

    logic r_in_double, r_in_single, r_escape, r_token_open, r_segment_open;
    logic n_in_double, n_in_single, n_escape, n_token_open, n_segment_open;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    logic       quoted;
    logic [7:0] c;
    logic [7:0] esc_val;
    logic       tok_at_close;

    assign c            = i_in.char_in;
    assign quoted       = r_in_double || r_in_single;
    assign tok_at_close = r_token_open || r_escape;

    always_comb begin
        esc_val = c;
        if (quoted) begin
            priority if (c == CH_LOWER_N) begin
                esc_val = CH_LF;
            end else if (c == CH_LOWER_T) begin
                esc_val = CH_TAB;
            end else if (c == CH_LOWER_R) begin
                esc_val = CH_CR;
            end else begin
                esc_val = c;
            end
        end
    end

    always_comb begin
        n_in_double    = r_in_double;
        n_in_single    = r_in_single;
        n_escape       = r_escape;
        n_token_open   = r_token_open;
        n_segment_open = r_segment_open;
        o_cmd.mask     = '0;
        o_cmd.ch       = CH_BACKSLASH;
        if (i_in.operation == OP_EOL || c == CH_PIPE) begin
            // pending backslash becomes literal, then close token and segment
            o_cmd.mask[MB_CHAR]  = r_escape;
            o_cmd.mask[MB_TOKEN] = tok_at_close;
            if (i_in.operation == OP_EOL) begin
                o_cmd.mask[MB_SEGMENT] = r_segment_open || r_escape;
                o_cmd.mask[MB_LINE]    = 1'b1;
            end else begin
                o_cmd.mask[MB_SEGMENT] = 1'b1;
            end
            n_in_double    = 1'b0;
            n_in_single    = 1'b0;
            n_escape       = 1'b0;
            n_token_open   = 1'b0;
            n_segment_open = 1'b0;
        end else begin
            n_segment_open = 1'b1;
            priority if (r_escape) begin
                n_escape             = 1'b0;
                o_cmd.mask[MB_CHAR]  = 1'b1;
                o_cmd.ch             = esc_val;
                n_token_open         = 1'b1;
            end else if (c == CH_DQUOTE && !r_in_single) begin
                n_in_double = !r_in_double;
            end else if (c == CH_SQUOTE && !r_in_double) begin
                n_in_single = !r_in_single;
            end else if (c == CH_BACKSLASH) begin
                n_escape = 1'b1;
            end else if (is_blank(c) && !quoted) begin
                o_cmd.mask[MB_TOKEN] = r_token_open;
                n_token_open         = 1'b0;
            end else begin
                o_cmd.mask[MB_CHAR] = 1'b1;
                o_cmd.ch            = c;
                n_token_open        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_double    <= 1'b0;
            r_in_single    <= 1'b0;
            r_escape       <= 1'b0;
            r_token_open   <= 1'b0;
            r_segment_open <= 1'b0;
        end else if (i_accept) begin
            r_in_double    <= n_in_double;
            r_in_single    <= n_in_single;
            r_escape       <= n_escape;
            r_token_open   <= n_token_open;
            r_segment_open <= n_segment_open;
        end
    end

endmodule

/* rtl/core/sqt_cmdq.sv */
// ----------------------------------------------------------------------------
// sqt_cmdq
// Short command queue between the lexer and the result expander.
// ----------------------------------------------------------------------------
module sqt_cmdq #(
    parameter int DEPTH = sqt_pkg::SQT_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sqt_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sqt_pkg::t_cmd o_data
);
    import sqt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/sqt_back.sv */
// ----------------------------------------------------------------------------
// sqt_back
// Expands queued commands into result items in an output register, one
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module sqt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sqt_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output sqt_pkg::t_out o_result
);
    import sqt_pkg::*;

    logic              r_cur_valid;
    t_cmd              r_cur;
    logic              r_out_valid;
    t_out              r_out;

    logic              out_free, take, refill;
    logic [MASK_W-1:0] low, rest;
    t_kind             kind;

    assign out_free = !r_out_valid || i_pop;
    assign take     = out_free && r_cur_valid;
    assign low      = r_cur.mask & (~r_cur.mask + MASK_W'(1));
    assign rest     = r_cur.mask & ~low;
    assign refill   = !r_cur_valid || (take && rest == '0);
    assign o_q_pop  = refill && i_q_valid;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        priority if (r_cur.mask[MB_CHAR]) begin
            kind = KIND_CHAR;
        end else if (r_cur.mask[MB_TOKEN]) begin
            kind = KIND_TOKEN_END;
        end else if (r_cur.mask[MB_SEGMENT]) begin
            kind = KIND_SEGMENT_END;
        end else begin
            kind = KIND_LINE_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.kind     <= kind;
            r_out.char_out <= (kind == KIND_CHAR) ? r_cur.ch : 8'h00;
            r_out.last     <= (rest == '0);
        end
        if (refill) begin
            r_cur <= i_q_data;
        end else if (take) begin
            r_cur.mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (refill) begin
                r_cur_valid <= i_q_valid;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/shell_quote_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// shell_quote_tokenizer_top
// Streaming lexer for one shell command line: quotes, escapes, tokens, pipes.
// ----------------------------------------------------------------------------
// Bytes of a command line are pushed one per transfer, followed by an
// end-of-line item; token characters, token ends, segment ends and the line
// end come out in order on the result side, with last set on the final
// result of each input item. Input is taken every cycle while full is low.
// An input item yields 0 to 4 results, each held in the output register
// until popped; the expander drains one result per cycle while results are
// popped, and the command queue (QUEUE_DEPTH entries) absorbs bursts; a
// plain text stream sustains one byte per cycle while results are popped.
// Results pass the command queue, the current-command register and the output register.
// ----------------------------------------------------------------------------
module shell_quote_tokenizer_top #(
    parameter int QUEUE_DEPTH = sqt_pkg::SQT_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sqt_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output sqt_pkg::t_out o_result
);
    import sqt_pkg::*;

    logic accept;
    t_cmd cmd;
    logic q_push, q_full, q_valid, q_pop;
    t_cmd q_data;

    assign full   = q_full;
    assign accept = push && !full;
    // items that cause no result never enter the queue
    assign q_push = accept && (cmd.mask != '0);

    sqt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_in    (i_in),
        .o_cmd   (cmd)
    );

    sqt_cmdq #(
        .DEPTH(QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    sqt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_data),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> q_valid)
        else $error("queue reports full with no valid entry");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("expander popped an empty queue");

    a_eol_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.operation == OP_EOL) |-> (q_push && cmd.mask[MB_LINE]))
        else $error("end of line did not queue a line end");

    a_pipe_seg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.operation == OP_CHAR && i_in.char_in == CH_PIPE)
            |-> (q_push && cmd.mask[MB_SEGMENT] && !cmd.mask[MB_LINE]))
        else $error("pipe did not queue a segment end");

endmodule
